/* design/skp_pkg.sv */
package skp_pkg;

  localparam int unsigned WindowMax  = 1024;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned PtrW       = $clog2(WindowMax);
  localparam int unsigned CntW       = PtrW + 1;
  localparam int unsigned SumW       = SampleBits + PtrW + 1;
  localparam int unsigned DW         = SumW + 1;
  localparam int unsigned PW         = DW + PtrW;
  localparam int unsigned PAbsW      = PW - 1;
  localparam int unsigned LoW        = (PAbsW + 1) / 2;
  localparam int unsigned HiW        = PAbsW - LoW;
  localparam int unsigned AccW       = 2 * PAbsW + PtrW;
  localparam int unsigned GW         = 2 * DW + PtrW;
  localparam int unsigned NumLags    = 8;
  localparam int unsigned LagW       = $clog2(NumLags);
  localparam int unsigned WgtW       = LagW + 2;
  localparam int unsigned VW         = GW + WgtW + LagW + 1;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned NumW       = AccW + LagW + 1 + FracBits;
  localparam int unsigned DenW       = VW + CntW;
  localparam int unsigned QW         = 32;
  localparam int unsigned RemW       = DenW + QW;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam int unsigned LagT1 = 100;
  localparam int unsigned LagT2 = 200;
  localparam int unsigned LagT3 = 400;
  localparam int unsigned LagT4 = 700;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic [PtrW-1:0]              wp;
    logic [CntW-1:0]              t;
    logic [PtrW-1:0]              start;
    logic                         too_short;
  } skp_task_t;

  typedef struct packed {
    logic full;
    logic empty;
  } skp_qstat_t;

  typedef enum logic [3:0] {
    BkIdle,
    BkWrite,
    BkSum,
    BkSumDrain,
    BkPass,
    BkPassDrain,
    BkComb,
    BkPrep,
    BkCheck,
    BkDiv,
    BkDone
  } skp_state_e;

  // round(4 * floor(t/100)^0.25) for t up to the window limit
  function automatic logic [LagW-1:0] lag_count(input logic [CntW-1:0] t);
    logic [LagW-1:0] l;
    if (t < CntW'(LagT1)) begin
      l = LagW'(0);
    end else if (t < CntW'(LagT2)) begin
      l = LagW'(4);
    end else if (t < CntW'(LagT3)) begin
      l = LagW'(5);
    end else if (t < CntW'(LagT4)) begin
      l = LagW'(6);
    end else begin
      l = LagW'(7);
    end
    return l;
  endfunction

endpackage

/* design/skp_ram.sv */
module skp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/skp_front.sv */
module skp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               window_size_we_i,
  input  logic [skp_pkg::CntW-1:0]           window_size_i,
  input  logic                               sample_valid_i,
  output logic                               sample_stall_o,
  input  logic signed [skp_pkg::SampleBits-1:0] sample_i,
  input  skp_pkg::skp_qstat_t                qstat_i,
  output logic                               push_o,
  output skp_pkg::skp_task_t                 task_o
);

  logic [skp_pkg::CntW-1:0] ws_q, ws_d;
  logic [skp_pkg::PtrW-1:0] wp_q, wp_d;
  logic [skp_pkg::CntW-1:0] fill_q, fill_d;
  logic [skp_pkg::CntW-1:0] eff, fill_inc;
  logic                     accept;

  assign accept         = sample_valid_i && !qstat_i.full;
  assign sample_stall_o = qstat_i.full;
  assign push_o         = accept;

  always_comb begin
    if (ws_q == '0) begin
      eff = skp_pkg::CntW'(1);
    end else if (ws_q > skp_pkg::CntW'(skp_pkg::WindowMax)) begin
      eff = skp_pkg::CntW'(skp_pkg::WindowMax);
    end else begin
      eff = ws_q;
    end
    fill_inc = (fill_q < skp_pkg::CntW'(skp_pkg::WindowMax)) ? fill_q + 1'b1 : fill_q;
    fill_d   = (fill_inc > eff) ? eff : fill_inc;
    wp_d     = wp_q + 1'b1;
    ws_d     = window_size_i;
  end

  always_comb begin
    task_o.sample    = sample_i;
    task_o.wp        = wp_q;
    task_o.t         = fill_d;
    task_o.start     = wp_d - fill_d[skp_pkg::PtrW-1:0];
    task_o.too_short = fill_d < skp_pkg::CntW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= skp_pkg::CntW'(skp_pkg::WindowMax);
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      if (window_size_we_i) begin
        ws_q <= ws_d;
      end
      if (accept) begin
        wp_q   <= wp_d;
        fill_q <= fill_d;
      end
    end
  end

endmodule

/* design/skp_queue.sv */
module skp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  skp_pkg::skp_task_t  task_i,
  input  logic                pop_i,
  output skp_pkg::skp_task_t  head_o,
  output skp_pkg::skp_qstat_t qstat_o
);

  skp_pkg::skp_task_t          slot_q [skp_pkg::QueueDepth];
  logic [skp_pkg::QPtrW-1:0]   wr_q, rd_q;
  logic [skp_pkg::QPtrW:0]     cnt_q, cnt_d;

  assign head_o        = slot_q[rd_q];
  assign qstat_o.full  = cnt_q == (skp_pkg::QPtrW + 1)'(skp_pkg::QueueDepth);
  assign qstat_o.empty = cnt_q == '0;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/skp_back.sv */
module skp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  skp_pkg::skp_task_t            head_i,
  input  skp_pkg::skp_qstat_t           qstat_i,
  output logic                          pop_o,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic [skp_pkg::QW-1:0]        statistic_o,
  output logic                          too_short_o,
  output logic                          zero_variance_o,
  output logic [skp_pkg::CntW-1:0]      samples_held_o
);

  localparam int unsigned NL = skp_pkg::NumLags;

  skp_pkg::skp_state_e state_q, state_d;
  skp_pkg::skp_task_t  task_q;

  logic [skp_pkg::CntW-1:0] cnt_q;
  logic                     issue, ram_we, rv_q, v2_q, v3_q, v4_q, v5_q;
  logic [skp_pkg::SampleBits-1:0] ram_rdata;
  logic signed [skp_pkg::SampleBits-1:0] rdata_s;
  logic [skp_pkg::PtrW-1:0] raddr;

  logic signed [skp_pkg::SumW-1:0]  sum_q, tx_q;
  logic signed [skp_pkg::SumW:0]    tx_full;
  logic signed [skp_pkg::DW-1:0]    d_q;
  logic signed [skp_pkg::DW-1:0]    hist_q [1:NL-1];
  logic [NL-1:1]                    hv_q;
  logic signed [2*skp_pkg::DW-1:0]  prod_q [NL];
  logic [NL-1:0]                    pv_q;
  logic signed [skp_pkg::PW-1:0]    p_q, p_neg;
  logic [skp_pkg::PAbsW-1:0]        pabs;
  logic [skp_pkg::HiW-1:0]          p_hi;
  logic [skp_pkg::LoW-1:0]          p_lo;
  logic [2*skp_pkg::HiW-1:0]        hh_q;
  logic [skp_pkg::HiW+skp_pkg::LoW-1:0] hl_q;
  logic [2*skp_pkg::LoW-1:0]        ll_q;
  logic signed [skp_pkg::GW-1:0]    g_q [NL];
  logic [skp_pkg::AccW-1:0]         acc_q;
  logic [skp_pkg::LagW-1:0]         lag_q, lag_sel;
  logic [skp_pkg::LagW:0]           lp1, lag_diff;
  logic [skp_pkg::WgtW-1:0]         wgt;
  logic signed [skp_pkg::VW-1:0]    var_q, wprod;
  logic [skp_pkg::NumW-1:0]         num_q;
  logic [skp_pkg::DenW-1:0]         den_q;
  logic [skp_pkg::RemW-1:0]         rem_q, dsh_q, den_top;
  logic [skp_pkg::QW-1:0]           quot_q;
  logic                             zv_q, sat_q, var_bad, over, bit_set;
  logic                             out_vld_q, load_out;
  logic [skp_pkg::QW-1:0]           stat_q, stat_d;
  logic                             short_out_q, zv_out_q;
  logic [skp_pkg::CntW-1:0]         held_q;

  skp_ram #(
    .Width(skp_pkg::SampleBits),
    .Depth(skp_pkg::WindowMax)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(task_q.wp),
    .wdata_i(task_q.sample),
    .re_i   (issue),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign rdata_s  = $signed(ram_rdata);
  assign raddr    = task_q.start + cnt_q[skp_pkg::PtrW-1:0];
  assign tx_full  = $signed({1'b0, task_q.t}) * rdata_s;
  assign p_neg    = -p_q;
  assign pabs     = p_q[skp_pkg::PW-1] ? p_neg[skp_pkg::PAbsW-1:0] : p_q[skp_pkg::PAbsW-1:0];
  assign p_lo     = pabs[skp_pkg::LoW-1:0];
  assign p_hi     = pabs[skp_pkg::PAbsW-1:skp_pkg::LoW];
  assign lag_sel  = cnt_q[skp_pkg::LagW-1:0];
  assign lp1      = {1'b0, lag_q} + 1'b1;
  assign lag_diff = lp1 - {1'b0, lag_sel};
  assign var_bad  = var_q[skp_pkg::VW-1] || (var_q == '0);
  assign den_top  = skp_pkg::RemW'(den_q) << skp_pkg::QW;
  assign over     = skp_pkg::RemW'(num_q) >= den_top;
  assign bit_set  = rem_q >= dsh_q;

  always_comb begin
    if (lag_sel == '0) begin
      wgt = skp_pkg::WgtW'(lp1);
    end else if (lag_sel <= lag_q) begin
      wgt = skp_pkg::WgtW'({lag_diff, 1'b0});
    end else begin
      wgt = '0;
    end
    wprod = skp_pkg::VW'(g_q[lag_sel]) * skp_pkg::VW'($signed({1'b0, wgt}));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skp_pkg::BkIdle: begin
        if (!qstat_i.empty) state_d = skp_pkg::BkWrite;
      end
      skp_pkg::BkWrite: begin
        state_d = task_q.too_short ? skp_pkg::BkDone : skp_pkg::BkSum;
      end
      skp_pkg::BkSum: begin
        if (cnt_q == task_q.t) state_d = skp_pkg::BkSumDrain;
      end
      skp_pkg::BkSumDrain: begin
        if (!rv_q) state_d = skp_pkg::BkPass;
      end
      skp_pkg::BkPass: begin
        if (cnt_q == task_q.t) state_d = skp_pkg::BkPassDrain;
      end
      skp_pkg::BkPassDrain: begin
        if (!(rv_q || v2_q || v3_q || v4_q || v5_q)) state_d = skp_pkg::BkComb;
      end
      skp_pkg::BkComb: begin
        if (lag_sel == skp_pkg::LagW'(NL - 1)) state_d = skp_pkg::BkPrep;
      end
      skp_pkg::BkPrep: begin
        state_d = var_bad ? skp_pkg::BkDone : skp_pkg::BkCheck;
      end
      skp_pkg::BkCheck: begin
        state_d = over ? skp_pkg::BkDone : skp_pkg::BkDiv;
      end
      skp_pkg::BkDiv: begin
        if (cnt_q == skp_pkg::CntW'(skp_pkg::QW - 1)) state_d = skp_pkg::BkDone;
      end
      skp_pkg::BkDone: begin
        if (!out_vld_q || !result_stall_i) state_d = skp_pkg::BkIdle;
      end
      default: state_d = skp_pkg::BkIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      skp_pkg::BkIdle:  pop_o    = !qstat_i.empty;
      skp_pkg::BkWrite: ram_we   = 1'b1;
      skp_pkg::BkSum:   issue    = cnt_q != task_q.t;
      skp_pkg::BkPass:  issue    = cnt_q != task_q.t;
      skp_pkg::BkDone:  load_out = !out_vld_q || !result_stall_i;
      default: begin
      end
    endcase
  end

  always_comb begin
    if (task_q.too_short) begin
      stat_d = '0;
    end else if (zv_q || sat_q) begin
      stat_d = '1;
    end else begin
      stat_d = quot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= skp_pkg::BkIdle;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else if (issue || state_q == skp_pkg::BkComb || state_q == skp_pkg::BkDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rv_q <= issue;
      v2_q <= rv_q && (state_q == skp_pkg::BkPass || state_q == skp_pkg::BkPassDrain);
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!result_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      task_q <= head_i;
    end
    if (state_q == skp_pkg::BkWrite) begin
      sum_q <= '0;
      p_q   <= '0;
      hv_q  <= '0;
      acc_q <= '0;
      var_q <= '0;
      zv_q  <= 1'b0;
      sat_q <= 1'b0;
      lag_q <= skp_pkg::lag_count(task_q.t);
      for (int s = 0; s < NL; s++) begin
        g_q[s] <= '0;
      end
    end else begin
      if (rv_q && (state_q == skp_pkg::BkSum || state_q == skp_pkg::BkSumDrain)) begin
        sum_q <= sum_q + skp_pkg::SumW'(rdata_s);
      end
      if (v3_q) begin
        p_q     <= p_q + skp_pkg::PW'(d_q);
        hv_q    <= {hv_q[NL-2:1], 1'b1};
        hist_q[1] <= d_q;
        for (int s = 2; s < NL; s++) begin
          hist_q[s] <= hist_q[s-1];
        end
      end
      if (v4_q) begin
        for (int s = 0; s < NL; s++) begin
          if (pv_q[s]) begin
            g_q[s] <= g_q[s] + skp_pkg::GW'(prod_q[s]);
          end
        end
      end
      if (v5_q) begin
        acc_q <= acc_q + (skp_pkg::AccW'(hh_q) << (2 * skp_pkg::LoW))
                       + (skp_pkg::AccW'(hl_q) << (skp_pkg::LoW + 1))
                       + skp_pkg::AccW'(ll_q);
      end
      if (state_q == skp_pkg::BkComb) begin
        var_q <= var_q + wprod;
      end
      if (state_q == skp_pkg::BkPrep) begin
        zv_q  <= var_bad;
        num_q <= (skp_pkg::NumW'(acc_q) * skp_pkg::NumW'(lp1)) << skp_pkg::FracBits;
        den_q <= skp_pkg::DenW'(var_q[skp_pkg::VW-2:0]) * skp_pkg::DenW'(task_q.t);
      end
      if (state_q == skp_pkg::BkCheck) begin
        sat_q  <= over;
        rem_q  <= skp_pkg::RemW'(num_q);
        dsh_q  <= skp_pkg::RemW'(den_q) << (skp_pkg::QW - 1);
        quot_q <= '0;
      end
      if (state_q == skp_pkg::BkDiv) begin
        if (bit_set) begin
          rem_q <= rem_q - dsh_q;
        end
        quot_q <= {quot_q[skp_pkg::QW-2:0], bit_set};
        dsh_q  <= dsh_q >> 1;
      end
    end
    tx_q <= tx_full[skp_pkg::SumW-1:0];
    d_q  <= skp_pkg::DW'(tx_q) - skp_pkg::DW'(sum_q);
    prod_q[0] <= d_q * d_q;
    pv_q[0]   <= 1'b1;
    for (int s = 1; s < NL; s++) begin
      prod_q[s] <= d_q * hist_q[s];
      pv_q[s]   <= hv_q[s];
    end
    hh_q <= p_hi * p_hi;
    hl_q <= p_hi * p_lo;
    ll_q <= p_lo * p_lo;
    if (load_out) begin
      stat_q      <= stat_d;
      short_out_q <= task_q.too_short;
      zv_out_q    <= !task_q.too_short && zv_q;
      held_q      <= task_q.t;
    end
  end

  assign result_valid_o  = out_vld_q;
  assign statistic_o     = stat_q;
  assign too_short_o     = short_out_q;
  assign zero_variance_o = zv_out_q;
  assign samples_held_o  = held_q;

endmodule

/* design/sliding_kpss_statistic_core.sv */
// Sliding-window KPSS level-stationarity statistic. Each sample request enters the window
// of the newest window_size samples (0 acts as 1, above 1024 as 1024) and yields one result:
// eta in unsigned Q16.16, truncated, saturating at all ones; too_short flags fewer than two
// samples held (statistic zero), zero_variance flags a non-positive long-run variance
// (statistic all ones). For each request the single read port of the sample memory is
// swept twice (mean, then residuals, partial sums and all lag products together),
// followed by an eight-step variance combine and a 32-step restoring division. A
// saturated or zero-variance result skips the division, and a request with fewer than
// two samples held skips both sweeps and the division. A two-entry queue lets up to two
// requests wait meanwhile.
module sliding_kpss_statistic_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  window_size_we_i,
  input  logic [skp_pkg::CntW-1:0]              window_size_i,
  input  logic                                  sample_valid_i,
  output logic                                  sample_stall_o,
  input  logic signed [skp_pkg::SampleBits-1:0] sample_i,
  output logic                                  result_valid_o,
  input  logic                                  result_stall_i,
  output logic [skp_pkg::QW-1:0]                statistic_o,
  output logic                                  too_short_o,
  output logic                                  zero_variance_o,
  output logic [skp_pkg::CntW-1:0]              samples_held_o
);

  skp_pkg::skp_qstat_t qstat;
  skp_pkg::skp_task_t  push_task, head_task;
  logic                push, pop;

  skp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .window_size_we_i(window_size_we_i),
    .window_size_i   (window_size_i),
    .sample_valid_i  (sample_valid_i),
    .sample_stall_o  (sample_stall_o),
    .sample_i        (sample_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .task_o          (push_task)
  );

  skp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .task_i (push_task),
    .pop_i  (pop),
    .head_o (head_task),
    .qstat_o(qstat)
  );

  skp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_task),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .statistic_o    (statistic_o),
    .too_short_o    (too_short_o),
    .zero_variance_o(zero_variance_o),
    .samples_held_o (samples_held_o)
  );

endmodule

/* design/skp_checker.sv */
module skp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         result_valid_o,
  input logic                         result_stall_i,
  input logic [skp_pkg::QW-1:0]       statistic_o,
  input logic                         too_short_o,
  input logic                         zero_variance_o,
  input logic [skp_pkg::CntW-1:0]     samples_held_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(too_short_o && zero_variance_o))
    else $error("both flags set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && too_short_o |-> statistic_o == '0 &&
      samples_held_o < skp_pkg::CntW'(2))
    else $error("short window result wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && zero_variance_o |-> statistic_o == '1 &&
      samples_held_o >= skp_pkg::CntW'(2))
    else $error("zero variance result wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !too_short_o |-> samples_held_o >= skp_pkg::CntW'(2) &&
      samples_held_o <= skp_pkg::CntW'(skp_pkg::WindowMax))
    else $error("samples held out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(statistic_o))
    else $error("stalled result changed");

endmodule

bind sliding_kpss_statistic_core skp_checker u_skp_checker (.*);

/* tb/tb_sliding_kpss_statistic_core.sv */
module tb_sliding_kpss_statistic_core;

  localparam int unsigned StallLimit = 50000;
  localparam int unsigned DrainCycles = 2 * skp_pkg::WindowMax + 120;

  typedef struct {
    logic [skp_pkg::QW-1:0]   statistic;
    logic                     too_short;
    logic                     zero_variance;
    logic [skp_pkg::CntW-1:0] samples_held;
  } kpss_result_t;

  class kpss_scoreboard;
    logic signed [skp_pkg::SampleBits-1:0] ring[skp_pkg::WindowMax];
    int unsigned wr_ptr;
    int unsigned held;
    int unsigned win;
    kpss_result_t pending_q[$];
    int unsigned mismatches;

    function new();
      wr_ptr = 0;
      held = 0;
      win = skp_pkg::WindowMax;
      mismatches = 0;
    endfunction

    function void set_window(logic [skp_pkg::CntW-1:0] v);
      win = v;
    endfunction

    function void note_request(logic signed [skp_pkg::SampleBits-1:0] x);
      int unsigned eff, t_len, first, l, n;
      longint sum, o;
      longint dev[skp_pkg::WindowMax];
      logic signed [255:0] part, acc, var_acc, lag_sum, a, b;
      logic [255:0] num, den;
      kpss_result_t r;
      ring[wr_ptr] = x;
      wr_ptr = (wr_ptr + 1) % skp_pkg::WindowMax;
      if (held < skp_pkg::WindowMax) held++;
      eff = win;
      if (eff < 1) eff = 1;
      if (eff > skp_pkg::WindowMax) eff = skp_pkg::WindowMax;
      if (held > eff) held = eff;
      t_len = held;
      r.samples_held = t_len[skp_pkg::CntW-1:0];
      r.statistic = '0;
      r.too_short = 1'b0;
      r.zero_variance = 1'b0;
      if (t_len < 2) begin
        r.too_short = 1'b1;
      end else begin
        first = (wr_ptr + skp_pkg::WindowMax - t_len) % skp_pkg::WindowMax;
        sum = 0;
        for (int i = 0; i < t_len; i++)
          sum += longint'(ring[(first + i) % skp_pkg::WindowMax]);
        for (int i = 0; i < t_len; i++)
          dev[i] = longint'(t_len) * longint'(ring[(first + i) % skp_pkg::WindowMax]) - sum;
        part = '0;
        acc = '0;
        for (int i = 0; i < t_len; i++) begin
          a = dev[i];
          part = part + a;
          acc = acc + part * part;
        end
        l = 0;
        for (n = 1; n < 64; n++) begin
          o = 2 * n - 1;
          if (o * o * o * o <= 4096 * longint'(t_len / 100)) l = n;
          else break;
        end
        var_acc = '0;
        for (int s = 0; s <= l; s++) begin
          lag_sum = '0;
          for (int t = s; t < t_len; t++) begin
            a = dev[t];
            b = dev[t - s];
            lag_sum = lag_sum + a * b;
          end
          if (s == 0) lag_sum = lag_sum * (l + 1);
          else lag_sum = lag_sum * (2 * (l + 1 - s));
          var_acc = var_acc + lag_sum;
        end
        if (var_acc <= 0) begin
          r.statistic = '1;
          r.zero_variance = 1'b1;
        end else begin
          num = acc * (l + 1) * 65536;
          den = var_acc * t_len;
          if (num >= (den << 32)) r.statistic = '1;
          else r.statistic = skp_pkg::QW'(num / den);
        end
      end
      pending_q = {pending_q, r};
    endfunction

    function void check_result(kpss_result_t got);
      kpss_result_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result statistic=%h", got.statistic);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.statistic !== exp_r.statistic || got.too_short !== exp_r.too_short ||
          got.zero_variance !== exp_r.zero_variance ||
          got.samples_held !== exp_r.samples_held) begin
        mismatches++;
        if (mismatches <= 10)
          $display("exp stat=%h ts=%b zv=%b held=%0d got stat=%h ts=%b zv=%b held=%0d",
                   exp_r.statistic, exp_r.too_short, exp_r.zero_variance, exp_r.samples_held,
                   got.statistic, got.too_short, got.zero_variance, got.samples_held);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic window_size_we_i = 1'b0;
  logic [skp_pkg::CntW-1:0] window_size_i = '0;
  logic sample_valid_i = 1'b0;
  logic sample_stall_o;
  logic signed [skp_pkg::SampleBits-1:0] sample_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic [skp_pkg::QW-1:0] statistic_o;
  logic too_short_o;
  logic zero_variance_o;
  logic [skp_pkg::CntW-1:0] samples_held_o;

  kpss_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic signed [skp_pkg::SampleBits-1:0] last_sample = '0;

  sliding_kpss_statistic_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .window_size_we_i(window_size_we_i),
    .window_size_i(window_size_i),
    .sample_valid_i(sample_valid_i),
    .sample_stall_o(sample_stall_o),
    .sample_i(sample_i),
    .result_valid_o(result_valid_o),
    .result_stall_i(result_stall_i),
    .statistic_o(statistic_o),
    .too_short_o(too_short_o),
    .zero_variance_o(zero_variance_o),
    .samples_held_o(samples_held_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    kpss_result_t got;
    if (rst_ni) begin
      if (result_valid_o && !result_stall_i) begin
        got.statistic = statistic_o;
        got.too_short = too_short_o;
        got.zero_variance = zero_variance_o;
        got.samples_held = samples_held_o;
        sb.check_result(got);
      end
      if ((result_valid_o && !result_stall_i) || (sample_valid_i && !sample_stall_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    result_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_sample(logic signed [skp_pkg::SampleBits-1:0] x);
    sample_valid_i <= 1'b1;
    sample_i <= x;
    do @(posedge clk_i); while (sample_stall_o);
    sb.note_request(x);
    last_sample = x;
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      sample_i <= skp_pkg::SampleBits'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window(logic [skp_pkg::CntW-1:0] v);
    window_size_we_i <= 1'b1;
    window_size_i <= v;
    @(posedge clk_i);
    window_size_we_i <= 1'b0;
    window_size_i <= skp_pkg::CntW'($urandom);
    sb.set_window(v);
  endtask

  function automatic logic signed [skp_pkg::SampleBits-1:0] pick_sample();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return skp_pkg::SampleBits'($urandom_range(16) - 8);
      2: return last_sample;
      default: return skp_pkg::SampleBits'($urandom);
    endcase
  endfunction

  task automatic set_idling(int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  task automatic random_run(logic [skp_pkg::CntW-1:0] w, int unsigned count,
                            int unsigned phase);
    write_window(w);
    set_idling(phase);
    for (int i = 0; i < count; i++) begin
      if (phase == 2 && i == count / 2) begin
        sample_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_q.size() != 0) @(posedge clk_i);
      end
      send_sample(pick_sample());
    end
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short window, constant run, extremes
    write_window(skp_pkg::CntW'(3));
    send_sample(16'sd7);
    send_sample(16'sd7);
    send_sample(16'sd7);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    wait_drain();
    write_window(skp_pkg::CntW'(0));
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    wait_drain();
    write_window(skp_pkg::CntW'(2));
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    send_sample(16'shaaaa);
    send_sample(16'sh0000);
    wait_drain();
    write_window(skp_pkg::CntW'(1));
    send_sample(16'sd4);
    wait_drain();

    // growing number of samples held so that the lag terms come into play
    random_run(skp_pkg::CntW'(2047), 35, 3);
    random_run(skp_pkg::CntW'(1024), 20, 1);
    random_run(skp_pkg::CntW'(150), 46, 2);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
